// ----- rtl/b64d_pkg.sv -----
package b64d_pkg;

   localparam logic [7:0] PAD_CODE = 8'h3D;
   localparam int NUM_RESULTS = 3;
   localparam int SEXTET_W = 6;
   localparam int BUFFER_W = 3 * SEXTET_W;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_CHAR   = 2'd1,
      ERR_PAD    = 2'd2,
      ERR_LENGTH = 2'd3
   } error_kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0]     data_byte;
      logic           end_of_run;
      logic           end_of_output;
      error_kind_type error_kind;
   } rsp_type;

   typedef struct packed {
      logic [1:0]          group_position;
      logic [BUFFER_W-1:0] sextet_buffer;
      logic [1:0]          pad_seen;
      logic                error_latched;
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [SEXTET_W-1:0] value;
   } sextet_type;

   function automatic sextet_type sextet_of(input logic [7:0] c);
      sextet_type s;
      s.valid = 1'b1;
      s.value = '0;
      case (c) inside
         [8'h41:8'h5A]: s.value = SEXTET_W'(c - 8'h41);
         [8'h61:8'h7A]: s.value = SEXTET_W'(c - 8'h61 + 8'd26);
         [8'h30:8'h39]: s.value = SEXTET_W'(c - 8'h30 + 8'd52);
         8'h2B:         s.value = SEXTET_W'(62);
         8'h2F:         s.value = SEXTET_W'(63);
         default:       s.valid = 1'b0;
      endcase
      return s;
   endfunction

endpackage

// ----- rtl/b64d_decode.sv -----
module b64d_decode
   import b64d_pkg::*;
(
   input  state_type                    state,
   input  req_type                      req,
   output state_type                    state_next,
   output rsp_type [NUM_RESULTS-1:0]    results,
   output logic [1:0]                   result_count
);

   sextet_type     sx;
   logic [SEXTET_W-1:0] s0, s1, s2, s3;
   logic [7:0]     bytes [NUM_RESULTS];
   logic [1:0]     pad_next;
   logic [1:0]     nbytes;
   error_kind_type err;
   logic           last;

   assign sx   = sextet_of(req.char_code);
   assign last = req.end_of_text;
   assign s0   = state.sextet_buffer[BUFFER_W-1 -: SEXTET_W];
   assign s1   = state.sextet_buffer[2*SEXTET_W-1 -: SEXTET_W];
   assign s2   = state.sextet_buffer[SEXTET_W-1:0];

   always_comb begin
      err      = ERR_NONE;
      pad_next = state.pad_seen;
      s3       = '0;
      if (req.char_code == PAD_CODE) begin
         if (state.group_position < 2'd2 || state.pad_seen >= 2'd2) begin
            err = ERR_PAD;
         end else if (state.group_position == 2'd2) begin
            pad_next = 2'd1;
         end else begin
            pad_next = state.pad_seen + 2'd1;
            if (!last) begin
               err = ERR_PAD;
            end
         end
      end else if (!sx.valid) begin
         err = ERR_CHAR;
      end else if (state.pad_seen != 2'd0) begin
         err = ERR_PAD;
      end else begin
         s3 = sx.value;
      end
   end

   assign bytes[0] = {s0, s1[5:4]};
   assign bytes[1] = {s1[3:0], s2[5:2]};
   assign bytes[2] = {s2[1:0], s3};
   assign nbytes   = (pad_next == 2'd0) ? 2'd3 : (pad_next == 2'd1) ? 2'd2 : 2'd1;

   always_comb begin
      state_next   = state;
      result_count = 2'd0;
      results      = '0;
      if (state.error_latched) begin
         if (last) begin
            state_next = '0;
         end
      end else if (err != ERR_NONE) begin
         result_count              = 2'd1;
         results[0].end_of_run     = 1'b1;
         results[0].end_of_output  = last;
         results[0].error_kind     = err;
         if (last) begin
            state_next = '0;
         end else begin
            state_next.error_latched = 1'b1;
         end
      end else if (state.group_position < 2'd3) begin
         state_next.sextet_buffer  = {state.sextet_buffer[2*SEXTET_W-1:0], s3};
         state_next.group_position = state.group_position + 2'd1;
         state_next.pad_seen       = pad_next;
         if (last) begin
            state_next                = '0;
            result_count              = 2'd1;
            results[0].end_of_run     = 1'b1;
            results[0].end_of_output  = 1'b1;
            results[0].error_kind     = ERR_LENGTH;
         end
      end else begin
         state_next   = '0;
         result_count = nbytes;
         for (int k = 0; k < NUM_RESULTS; k++) begin
            results[k].data_byte     = bytes[k];
            results[k].end_of_run    = (2'(k + 1) == nbytes);
            results[k].end_of_output = (2'(k + 1) == nbytes) && last;
            results[k].error_kind    = ERR_NONE;
         end
      end
   end

endmodule

// ----- rtl/base64_decoder_checked.sv -----
// Streaming base64 decoder for the standard alphabet. One character is taken per
// transaction, with end_of_text on the final character of the text; every fourth
// character completes a group and yields one to three byte results, and a bad
// character, misplaced padding or a bad length yields a single error result, after
// which input is dropped up to the end flag. A character is accepted every cycle
// unless the input stalls: it is held in the input register, decoded there against
// the group state, and its results are registered in a three-entry result register
// that issues one per cycle while rsp_stall is low. The input stalls only while
// results of an earlier character remain that are not all taken in that cycle and
// the new one produces results too, so the sustained rate is one character per cycle
// on valid text while rsp_stall is low (three bytes per four characters).
module base64_decoder_checked
   import b64d_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic                      req_valid_ff, req_valid_in;
   req_type                   req_ff, req_in;
   state_type                 state_ff, state_in, state_dec;
   rsp_type [NUM_RESULTS-1:0] res_ff, res_in, res_dec;
   logic [1:0]                cnt_ff, cnt_in, cnt_dec;
   logic                      pop, free, consume;

   b64d_decode u_decode (
      .state        (state_ff),
      .req          (req_ff),
      .state_next   (state_dec),
      .results      (res_dec),
      .result_count (cnt_dec)
   );

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = res_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign free      = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop);
   assign consume   = req_valid_ff && (free || cnt_dec == 2'd0);
   assign req_stall = req_valid_ff && !consume;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in       = req_ff;
      if (!req_stall) begin
         req_valid_in = req_valid;
         req_in       = req_data;
      end
   end

   assign state_in = consume ? state_dec : state_ff;

   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (consume && cnt_dec != 2'd0) begin
         res_in = res_dec;
         cnt_in = cnt_dec;
      end else if (pop) begin
         res_in = {rsp_type'('0), res_ff[NUM_RESULTS-1:1]};
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         state_ff     <= '0;
         cnt_ff       <= 2'd0;
      end else begin
         req_valid_ff <= req_valid_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      res_ff <= res_in;
   end

`ifndef SYNTHESIS
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && !req_valid_ff)
      else $error("results pending after reset");

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_kind != ERR_NONE |->
         rsp_data.data_byte == 8'd0 && rsp_data.end_of_run)
      else $error("error result carries data or is not last of its run");

   a_output_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_of_output |-> rsp_data.end_of_run && cnt_ff == 2'd1)
      else $error("end of output not on the last pending result");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !consume |=> req_valid_ff && $stable(req_ff))
      else $error("held character changed while stalled");
`endif

endmodule
